// ----- sv/bile_pkg.sv -----
// ----------------------------------------------------------------------------
// bile_pkg
// Shared constants, action codes and status codes of the bounded list engine.
// ----------------------------------------------------------------------------
package bile_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 7;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_TAIL = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POLL     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ORD_INS  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_UNQ_INS  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Value reported when nothing is found or the list is empty
  localparam logic [VALUE_W-1:0] VAL_NONE = {VALUE_W{1'b1}};

endpackage

// ----- sv/bile_in_if.sv -----
// ----------------------------------------------------------------------------
// bile_in_if
// Command channel: one action with its operand per transfer.
// ----------------------------------------------------------------------------
interface bile_in_if;

  logic                                valid;
  logic                                ready;
  logic [bile_pkg::ACTION_W-1:0]       action;
  logic signed [bile_pkg::VALUE_W-1:0] operand_value;

  modport source (output valid, action, operand_value, input ready);
  modport sink   (input valid, action, operand_value, output ready);

endinterface

// ----- sv/bile_out_if.sv -----
// ----------------------------------------------------------------------------
// bile_out_if
// Result channel: one result per command.
// ----------------------------------------------------------------------------
interface bile_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [bile_pkg::VALUE_W-1:0] result_value;
  logic [bile_pkg::STATUS_W-1:0]       status;
  logic [bile_pkg::ENTRY_W-1:0]        entry_count;

  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);

endinterface

// ----- sv/bounded_int_list_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_int_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with deque operations.
// ----------------------------------------------------------------------------
// The engine holds the list in one RAM (head at address 0) and works on one
// command at a time; each command yields exactly one result. Append,
// full-list refusals and reads of an empty list go straight to the output
// step; peek and pop read the RAM first. Poll, contains, remove and the
// inserts walk the list: every entry scanned or shifted costs one RAM read and
// one compare or write-back, since the RAM has one read port with registered
// read data. A finished result waits in an output register, and a new command
// is taken once the previous one has moved its result there.
// ----------------------------------------------------------------------------
module bounded_int_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  bile_in_if.sink     in_ch,
  bile_out_if.source  out_ch
);

  localparam int CNT_W   = bile_pkg::CNT_W;
  localparam int IDX_W   = bile_pkg::IDX_W;
  localparam int VALUE_W = bile_pkg::VALUE_W;
  localparam int ENTRY_W = bile_pkg::ENTRY_W;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(bile_pkg::CAPACITY);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDRES    = 4'd1;
  localparam logic [3:0] S_POLL     = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_OPEN_RD  = 4'd5;
  localparam logic [3:0] S_OPEN_WR  = 4'd6;
  localparam logic [3:0] S_CLOSE_RD = 4'd7;
  localparam logic [3:0] S_CLOSE_WR = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [CNT_W-1:0]               pos_r, pos_nxt;
  logic [bile_pkg::ACTION_W-1:0]  act_r, act_nxt;
  logic [VALUE_W-1:0]             val_r, val_nxt;
  logic [VALUE_W-1:0]             res_r, res_nxt;
  logic [bile_pkg::STATUS_W-1:0]  st_r, st_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]             out_value_r, out_value_nxt;
  logic [bile_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]             out_count_r, out_count_nxt;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [VALUE_W-1:0]             ram_wdata;
  logic [IDX_W-1:0]               ram_raddr;
  logic [VALUE_W-1:0]             ram_rdata;

  logic                           in_xfer;
  logic                           is_insert;
  logic                           is_full;
  logic                           is_empty;
  logic [CNT_W-1:0]               idx_m1;
  logic [CNT_W-1:0]               idx_p1;
  logic [CNT_W-1:0]               cnt_m1;
  logic [CNT_W+ENTRY_W-1:0]       cnt_ext;

  // List storage
  bile_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (bile_pkg::CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and helpers
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_insert   = (act_r == bile_pkg::ACT_ORD_INS) || (act_r == bile_pkg::ACT_UNQ_INS);
  assign is_full     = (count_r == CNT_FULL);
  assign is_empty    = (count_r == '0);
  assign idx_m1      = idx_r - CNT_ONE;
  assign idx_p1      = idx_r + CNT_ONE;
  assign cnt_m1      = count_r - CNT_ONE;
  assign cnt_ext     = {{ENTRY_W{1'b0}}, count_nxt};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    res_nxt        = res_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[IDX_W-1:0];
    ram_wdata      = val_r;
    ram_raddr      = idx_r[IDX_W-1:0];

    // result register drains on transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt = in_ch.action;
          val_nxt = in_ch.operand_value;
          idx_nxt = '0;
          res_nxt = '0;
          st_nxt  = bile_pkg::ST_OK;
          unique case (in_ch.action)
            bile_pkg::ACT_APPEND: begin
              state_nxt = S_OUT;
              if (is_full) begin
                st_nxt = bile_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[IDX_W-1:0];
                ram_wdata = in_ch.operand_value;
                count_nxt = count_r + CNT_ONE;
              end
            end
            bile_pkg::ACT_POP_TAIL, bile_pkg::ACT_POLL, bile_pkg::ACT_PEEK: begin
              if (is_empty) begin
                res_nxt   = bile_pkg::VAL_NONE;
                st_nxt    = bile_pkg::ST_EMPTY;
                state_nxt = S_OUT;
              end else if (in_ch.action == bile_pkg::ACT_POP_TAIL) begin
                ram_raddr = cnt_m1[IDX_W-1:0];
                state_nxt = S_RDRES;
              end else begin
                ram_raddr = '0;
                state_nxt = (in_ch.action == bile_pkg::ACT_POLL) ? S_POLL : S_RDRES;
              end
            end
            bile_pkg::ACT_ORD_INS, bile_pkg::ACT_UNQ_INS: begin
              if (is_full) begin
                st_nxt    = bile_pkg::ST_FULL;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
              // remove and contains
              state_nxt = S_SCAN_RD;
            end
          endcase
        end
      end

      // pop and peek: read data is the result
      S_RDRES: begin
        res_nxt = ram_rdata;
        st_nxt  = bile_pkg::ST_OK;
        if (act_r == bile_pkg::ACT_POP_TAIL) begin
          count_nxt = cnt_m1;
        end
        state_nxt = S_OUT;
      end

      // poll: take the head, then close the gap from position 0
      S_POLL: begin
        res_nxt   = ram_rdata;
        st_nxt    = bile_pkg::ST_OK;
        idx_nxt   = '0;
        state_nxt = S_CLOSE_RD;
      end

      // scan: fetch entry idx or end at the tail
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          if (is_insert) begin
            pos_nxt   = idx_r;
            state_nxt = S_OPEN_RD;
          end else begin
            res_nxt   = bile_pkg::VAL_NONE;
            st_nxt    = bile_pkg::ST_NOTFOUND;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      // scan: compare entry idx against the operand
      S_SCAN_CMP: begin
        state_nxt = S_SCAN_RD;
        idx_nxt   = idx_p1;
        if (is_insert) begin
          if ($signed(val_r) < $signed(ram_rdata)) begin
            pos_nxt   = idx_r;
            idx_nxt   = count_r;
            state_nxt = S_OPEN_RD;
          end else if ((act_r == bile_pkg::ACT_UNQ_INS) && (val_r == ram_rdata)) begin
            st_nxt    = bile_pkg::ST_DUP;
            state_nxt = S_OUT;
          end
        end else if (val_r == ram_rdata) begin
          res_nxt = val_r;
          st_nxt  = bile_pkg::ST_OK;
          if (act_r == bile_pkg::ACT_REMOVE) begin
            idx_nxt   = idx_r;
            state_nxt = S_CLOSE_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      // open gap: move entries up from the tail, then drop the value in
      S_OPEN_RD: begin
        if (idx_r == pos_r) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          count_nxt = count_r + CNT_ONE;
          res_nxt   = '0;
          st_nxt    = bile_pkg::ST_OK;
          state_nxt = S_OUT;
        end else begin
          ram_raddr = idx_m1[IDX_W-1:0];
          state_nxt = S_OPEN_WR;
        end
      end

      S_OPEN_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_m1;
        state_nxt = S_OPEN_RD;
      end

      // close gap: move entries down toward the removed slot
      S_CLOSE_RD: begin
        if (idx_p1 == count_r) begin
          count_nxt = cnt_m1;
          state_nxt = S_OUT;
        end else begin
          ram_raddr = idx_p1[IDX_W-1:0];
          state_nxt = S_CLOSE_WR;
        end
      end

      S_CLOSE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_p1;
        state_nxt = S_CLOSE_RD;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = st_r;
          out_count_nxt  = cnt_ext[ENTRY_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    res_r        <= res_nxt;
    st_r         <= st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_count  = out_count_r;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count beyond capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) <= count_r))
    else $error("RAM write outside the used region");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + CNT_ONE) || (count_r + CNT_ONE == $past(count_r))))
    else $error("entry count moved by more than one");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == bile_pkg::ST_EMPTY)) |-> (out_count_r == '0))
    else $error("empty status with entries held");

endmodule

// ----- sv/bile_ram.sv -----
// ----------------------------------------------------------------------------
// bile_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded ordered integer list engine. A shadow
// copy of the list, kept in a queue, predicts every result when its command
// transfers. A monitor compares each result transfer field by field with the
// oldest prediction. Directed tests cover the empty and full list, extreme
// values and every action. A long receiver stall fills the engine. Random
// traffic then drives the list from empty to full and back under three
// idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [bile_pkg::VALUE_W-1:0] value;
    logic [bile_pkg::STATUS_W-1:0]       status;
    logic [bile_pkg::ENTRY_W-1:0]        count;
  } list_result_t;

  logic clk;
  logic rst_n;

  bile_in_if  cmd_ch ();
  bile_out_if res_ch ();

  bounded_int_list_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  // Shadow list (head at index 0) and predicted results in command order
  logic signed [bile_pkg::VALUE_W-1:0] shadow_list[$];
  list_result_t                        pending_results[$];

  int err_count     = 0;
  int cmd_count     = 0;
  int checked_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int action_seen[8];
  int status_seen[5];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("Timeout at %0t with %0d results outstanding", $time, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Applies one action to the shadow list and returns the expected result
  function automatic list_result_t apply_list_op(
    input logic [bile_pkg::ACTION_W-1:0]       act,
    input logic signed [bile_pkg::VALUE_W-1:0] val
  );
    list_result_t r;
    int pos;
    bit dup;
    r.value  = '0;
    r.status = bile_pkg::ST_OK;
    pos      = 0;
    dup      = 1'b0;
    unique case (act)
      bile_pkg::ACT_APPEND: begin
        if (shadow_list.size() >= bile_pkg::CAPACITY) r.status = bile_pkg::ST_FULL;
        else shadow_list.push_back(val);
      end
      bile_pkg::ACT_POP_TAIL, bile_pkg::ACT_POLL, bile_pkg::ACT_PEEK: begin
        if (shadow_list.size() == 0) begin
          r.value  = bile_pkg::VAL_NONE;
          r.status = bile_pkg::ST_EMPTY;
        end else if (act == bile_pkg::ACT_POP_TAIL) begin
          r.value = shadow_list.pop_back();
        end else if (act == bile_pkg::ACT_POLL) begin
          r.value = shadow_list.pop_front();
        end else begin
          r.value = shadow_list[0];
        end
      end
      bile_pkg::ACT_ORD_INS, bile_pkg::ACT_UNQ_INS: begin
        // fullness wins over the duplicate check
        if (shadow_list.size() >= bile_pkg::CAPACITY) begin
          r.status = bile_pkg::ST_FULL;
        end else begin
          // stop at the first greater entry; an equal one on the way is a duplicate
          while (pos < shadow_list.size() && val >= shadow_list[pos]) begin
            if (act == bile_pkg::ACT_UNQ_INS && val == shadow_list[pos]) begin
              dup = 1'b1;
              break;
            end
            pos++;
          end
          if (dup) r.status = bile_pkg::ST_DUP;
          else shadow_list.insert(pos, val);
        end
      end
      default: begin
        // remove and contains look for the first equal entry
        r.value  = bile_pkg::VAL_NONE;
        r.status = bile_pkg::ST_NOTFOUND;
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (shadow_list[i] == val) begin
            if (act == bile_pkg::ACT_REMOVE) shadow_list.delete(i);
            r.value  = val;
            r.status = bile_pkg::ST_OK;
            break;
          end
        end
      end
    endcase
    r.count = bile_pkg::ENTRY_W'(shadow_list.size());
    return r;
  endfunction

  // Offers one command, waits for its transfer and records the prediction
  task automatic send_cmd(input logic [bile_pkg::ACTION_W-1:0]       act,
                          input logic signed [bile_pkg::VALUE_W-1:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.action        <= act;
    cmd_ch.operand_value <= val;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_results.push_back(apply_list_op(act, val));
    action_seen[act]++;
    cmd_count++;
  endtask

  // Result monitor
  initial begin
    list_result_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d count=%0d", $time,
                   res_ch.result_value, res_ch.status, res_ch.entry_count);
          err_count++;
        end else begin
          exp_r = pending_results.pop_front();
          checked_count++;
          if (res_ch.result_value !== exp_r.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     exp_r.value, res_ch.result_value);
            err_count++;
          end
          if (res_ch.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, res_ch.status);
            err_count++;
          end
          if (res_ch.entry_count !== exp_r.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     exp_r.count, res_ch.entry_count);
            err_count++;
          end
          if (exp_r.status < 5) status_seen[exp_r.status]++;
        end
      end
    end
  end

  // Result ready: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Operand mix: small values for hits and duplicates, held values, extremes, full range
  function automatic logic signed [bile_pkg::VALUE_W-1:0] pick_operand();
    int roll;
    int k;
    roll = $urandom_range(99, 0);
    if (roll < 40) begin
      k = $urandom_range(15, 0);
      return k - 8;
    end else if (roll < 60 && shadow_list.size() > 0) begin
      return shadow_list[$urandom_range(shadow_list.size() - 1, 0)];
    end else if (roll < 70) begin
      case ($urandom_range(3, 0))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Every read action on an empty list
  task automatic test_empty_list();
    send_cmd(bile_pkg::ACT_POP_TAIL, 32'sd0);
    send_cmd(bile_pkg::ACT_POLL, 32'sd0);
    send_cmd(bile_pkg::ACT_PEEK, 32'sd0);
    send_cmd(bile_pkg::ACT_REMOVE, 32'sd0);
    send_cmd(bile_pkg::ACT_CONTAINS, -32'sd1);
  endtask

  // Each action with extreme and ordinary operands
  task automatic test_each_action();
    send_cmd(bile_pkg::ACT_ORD_INS, -32'sd1);
    send_cmd(bile_pkg::ACT_ORD_INS, 32'sh8000_0000);
    send_cmd(bile_pkg::ACT_ORD_INS, 32'sh7FFF_FFFF);
    send_cmd(bile_pkg::ACT_ORD_INS, 32'sd0);
    send_cmd(bile_pkg::ACT_UNQ_INS, 32'sd0);
    send_cmd(bile_pkg::ACT_UNQ_INS, 32'sd5);
    send_cmd(bile_pkg::ACT_ORD_INS, 32'sd5);
    send_cmd(bile_pkg::ACT_APPEND, -32'sd7);
    send_cmd(bile_pkg::ACT_CONTAINS, 32'sh8000_0000);
    send_cmd(bile_pkg::ACT_CONTAINS, 32'sd12345);
    send_cmd(bile_pkg::ACT_PEEK, 32'sd0);
    send_cmd(bile_pkg::ACT_REMOVE, 32'sd5);
    send_cmd(bile_pkg::ACT_REMOVE, 32'sd99);
    send_cmd(bile_pkg::ACT_POP_TAIL, 32'sd0);
    send_cmd(bile_pkg::ACT_POLL, 32'sd0);
    while (shadow_list.size() > 0) send_cmd(bile_pkg::ACT_POLL, 32'sd0);
  endtask

  // Fill to capacity, hit every refused insert, then drain from both ends
  task automatic test_full_list();
    logic signed [bile_pkg::VALUE_W-1:0] held;
    while (shadow_list.size() < bile_pkg::CAPACITY) send_cmd(bile_pkg::ACT_ORD_INS, $urandom);
    held = shadow_list[0];
    send_cmd(bile_pkg::ACT_APPEND, 32'sd1);
    send_cmd(bile_pkg::ACT_ORD_INS, 32'sd1);
    // duplicate operand: must still report full
    send_cmd(bile_pkg::ACT_UNQ_INS, held);
    send_cmd(bile_pkg::ACT_CONTAINS, shadow_list[bile_pkg::CAPACITY-1]);
    send_cmd(bile_pkg::ACT_REMOVE, shadow_list[bile_pkg::CAPACITY-1]);
    send_cmd(bile_pkg::ACT_APPEND, 32'sh7FFF_FFFF);
    while (shadow_list.size() > 0)
      send_cmd($urandom_range(1, 0) ? bile_pkg::ACT_POP_TAIL : bile_pkg::ACT_POLL, 32'sd0);
  endtask

  // Long receiver stall while commands keep coming
  task automatic test_backpressure();
    hold_request = 400;
    repeat (16) send_cmd(bile_pkg::ACT_ORD_INS, pick_operand());
    while (shadow_list.size() > 0) send_cmd(bile_pkg::ACT_POLL, 32'sd0);
  endtask

  // Random traffic that swings the list between empty and full
  task automatic test_random_ops(input int n_cmds);
    bit growing;
    int roll;
    logic [bile_pkg::ACTION_W-1:0] act;
    growing = 1'b1;
    repeat (n_cmds) begin
      if (shadow_list.size() >= bile_pkg::CAPACITY && $urandom_range(3, 0) == 0) growing = 1'b0;
      if (shadow_list.size() == 0) growing = 1'b1;
      roll = $urandom_range(99, 0);
      if (growing) begin
        if      (roll < 20) act = bile_pkg::ACT_APPEND;
        else if (roll < 45) act = bile_pkg::ACT_ORD_INS;
        else if (roll < 65) act = bile_pkg::ACT_UNQ_INS;
        else if (roll < 70) act = bile_pkg::ACT_POP_TAIL;
        else if (roll < 75) act = bile_pkg::ACT_POLL;
        else if (roll < 80) act = bile_pkg::ACT_PEEK;
        else if (roll < 90) act = bile_pkg::ACT_REMOVE;
        else                act = bile_pkg::ACT_CONTAINS;
      end else begin
        if      (roll < 5)  act = bile_pkg::ACT_APPEND;
        else if (roll < 13) act = bile_pkg::ACT_ORD_INS;
        else if (roll < 20) act = bile_pkg::ACT_UNQ_INS;
        else if (roll < 40) act = bile_pkg::ACT_POP_TAIL;
        else if (roll < 60) act = bile_pkg::ACT_POLL;
        else if (roll < 65) act = bile_pkg::ACT_PEEK;
        else if (roll < 90) act = bile_pkg::ACT_REMOVE;
        else                act = bile_pkg::ACT_CONTAINS;
      end
      send_cmd(act, pick_operand());
    end
  endtask

  // Stop offering, let every result arrive, then report
  task automatic finish_run();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Sent %0d commands, checked %0d results", cmd_count, checked_count);
    $display("Actions 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             action_seen[0], action_seen[1], action_seen[2], action_seen[3],
             action_seen[4], action_seen[5], action_seen[6], action_seen[7]);
    $display("Statuses ok/empty/full/dup/not_found: %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  // Test sequence
  initial begin
    rst_n                = 1'b0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.action        = bile_pkg::ACT_PEEK;
    cmd_ch.operand_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 68;
    test_empty_list();
    test_each_action();
    test_full_list();
    test_backpressure();
    test_random_ops(540);

    send_idle_pct = 68;
    recv_idle_pct = 9;
    test_random_ops(540);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(540);

    finish_run();
  end

endmodule
